[src/vri_pkg.sv]
// Shared types and fixed field widths for the volume ratio indicator.
package vri_pkg;

  localparam int unsigned PriceW = 32;
  localparam int unsigned VolW   = 32;
  localparam int unsigned RatioW = 32;
  localparam int unsigned WinW   = 9;
  localparam int unsigned WinReset = 26;

  typedef enum logic [1:0] {
    CLS_UP   = 2'd1,
    CLS_DOWN = 2'd2,
    CLS_FLAT = 2'd3
  } cls_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_UPD,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CHK,
    B_DIV,
    B_DONE
  } back_state_e;

endpackage

[src/vri_front.sv]
// Front end: bar intake, up/down/flat marking, volume ring and running class sums.
module vri_front #(
  parameter int unsigned MAX_WINDOW = 256,
  parameter int unsigned SUM_W      = 40
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [vri_pkg::WinW-1:0]        window_length_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [vri_pkg::PriceW-1:0]      close_price_i,
  input  logic [vri_pkg::VolW-1:0]        volume_i,
  output logic                            push_valid_o,
  input  logic                            push_ready_i,
  output logic [SUM_W:0]                  push_num_o,
  output logic [SUM_W:0]                  push_den_o
);

  localparam int unsigned PW    = $clog2(MAX_WINDOW);
  localparam int unsigned NW    = PW + 1;
  localparam int unsigned CW    = (NW > vri_pkg::WinW) ? NW : vri_pkg::WinW;
  localparam int unsigned EW    = 2 + vri_pkg::VolW;
  localparam int unsigned NUM_W = SUM_W + 1;

  vri_pkg::front_state_e state_q, state_d;
  logic [vri_pkg::WinW-1:0]   window_q, window_d;
  logic [vri_pkg::PriceW-1:0] prev_q, prev_d;
  logic [PW-1:0]              ptr_q, ptr_d;
  logic [NW-1:0]              bars_q, bars_d;
  logic [SUM_W-1:0]           up_q, up_d, down_q, down_d, flat_q, flat_d;
  vri_pkg::cls_e              cls_q, cls_d;
  logic [vri_pkg::VolW-1:0]   vol_q, vol_d;
  logic                       evict_q, evict_d, emit_q, emit_d;
  logic [EW-1:0]              rd_q;
  logic [EW-1:0]              ring_mem [MAX_WINDOW];
  logic                       mem_we;

  logic [CW-1:0]    win_ext;
  logic [NW-1:0]    n_w, ptr_ext, old_ext;
  logic [PW-1:0]    old_addr;
  vri_pkg::cls_e    cls_new;
  logic [1:0]       old_cls;
  logic [SUM_W-1:0] vol_ext, old_vol;

  // window 0 behaves as 1, anything past the ring depth as the full ring
  assign win_ext = CW'(window_q);
  always_comb begin
    if (window_q == '0) begin
      n_w = NW'(1);
    end else if (win_ext > CW'(MAX_WINDOW)) begin
      n_w = NW'(MAX_WINDOW);
    end else begin
      n_w = NW'(win_ext);
    end
  end

  assign ptr_ext = NW'(ptr_q);
  always_comb begin
    if (ptr_ext >= n_w) begin
      old_ext = ptr_ext - n_w;
    end else begin
      old_ext = ptr_ext + NW'(MAX_WINDOW) - n_w;
    end
  end
  assign old_addr = old_ext[PW-1:0];

  always_comb begin
    if (close_price_i > prev_q) begin
      cls_new = vri_pkg::CLS_UP;
    end else if (close_price_i < prev_q) begin
      cls_new = vri_pkg::CLS_DOWN;
    end else begin
      cls_new = vri_pkg::CLS_FLAT;
    end
  end

  assign old_cls = rd_q[EW-1:vri_pkg::VolW];
  assign old_vol = SUM_W'(rd_q[vri_pkg::VolW-1:0]);
  assign vol_ext = SUM_W'(vol_q);

  assign push_num_o = {up_q, 1'b0} + NUM_W'(flat_q);
  assign push_den_o = {down_q, 1'b0} + NUM_W'(flat_q);

  always_comb begin
    state_d  = state_q;
    window_d = window_q;
    prev_d   = prev_q;
    ptr_d    = ptr_q;
    bars_d   = bars_q;
    up_d     = up_q;
    down_d   = down_q;
    flat_d   = flat_q;
    cls_d    = cls_q;
    vol_d    = vol_q;
    evict_d  = evict_q;
    emit_d   = emit_q;
    mem_we   = 1'b0;
    push_valid_o = 1'b0;
    cfg_ready_o  = (state_q == vri_pkg::F_IDLE);
    in_ready_o   = (state_q == vri_pkg::F_IDLE) && !cfg_valid_i;

    case (state_q)
      vri_pkg::F_IDLE: begin
        if (cfg_valid_i) begin
          window_d = window_length_i;
          ptr_d    = '0;
          bars_d   = '0;
          up_d     = '0;
          down_d   = '0;
          flat_d   = '0;
        end else if (in_valid_i) begin
          prev_d  = close_price_i;
          cls_d   = cls_new;
          vol_d   = volume_i;
          evict_d = (bars_q > n_w);
          emit_d  = (bars_q >= n_w);
          if (bars_q <= n_w) begin
            bars_d = bars_q + NW'(1);
          end
          // first bar after a restart only primes the previous close
          if (bars_q != '0) begin
            state_d = vri_pkg::F_UPD;
          end
        end
      end
      vri_pkg::F_UPD: begin
        mem_we = 1'b1;
        up_d   = up_q
               + ((cls_q == vri_pkg::CLS_UP) ? vol_ext : SUM_W'(0))
               - ((evict_q && old_cls == vri_pkg::CLS_UP) ? old_vol : SUM_W'(0));
        down_d = down_q
               + ((cls_q == vri_pkg::CLS_DOWN) ? vol_ext : SUM_W'(0))
               - ((evict_q && old_cls == vri_pkg::CLS_DOWN) ? old_vol : SUM_W'(0));
        flat_d = flat_q
               + ((cls_q == vri_pkg::CLS_FLAT) ? vol_ext : SUM_W'(0))
               - ((evict_q && old_cls == vri_pkg::CLS_FLAT) ? old_vol : SUM_W'(0));
        ptr_d  = (ptr_q == PW'(MAX_WINDOW - 1)) ? '0 : ptr_q + PW'(1);
        state_d = emit_q ? vri_pkg::F_PUSH : vri_pkg::F_IDLE;
      end
      vri_pkg::F_PUSH: begin
        push_valid_o = 1'b1;
        if (push_ready_i) begin
          state_d = vri_pkg::F_IDLE;
        end
      end
      default: begin
        state_d = vri_pkg::F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= vri_pkg::F_IDLE;
      window_q <= vri_pkg::WinW'(vri_pkg::WinReset);
      prev_q   <= '0;
      ptr_q    <= '0;
      bars_q   <= '0;
      up_q     <= '0;
      down_q   <= '0;
      flat_q   <= '0;
      evict_q  <= 1'b0;
      emit_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      window_q <= window_d;
      prev_q   <= prev_d;
      ptr_q    <= ptr_d;
      bars_q   <= bars_d;
      up_q     <= up_d;
      down_q   <= down_d;
      flat_q   <= flat_d;
      evict_q  <= evict_d;
      emit_q   <= emit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q <= cls_d;
    vol_q <= vol_d;
  end

  // oldest entry is fetched on the accept edge, before this bar is written
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[ptr_q] <= {cls_q, vol_q};
    end
    if (state_q == vri_pkg::F_IDLE) begin
      rd_q <= ring_mem[old_addr];
    end
  end

endmodule

[src/vri_queue.sv]
// Two-entry queue carrying numerator/denominator pairs from front to back.
module vri_queue #(
  parameter int unsigned W = 82
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  logic [W-1:0] slot_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   cnt_q;
  logic         push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[src/vri_back.sv]
// Back end: scale by 100 and 2^F, bit-serial divide, saturate, output register.
module vri_back #(
  parameter int unsigned NUM_W         = 41,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           pop_valid_i,
  output logic                           pop_ready_o,
  input  logic [NUM_W-1:0]               num_i,
  input  logic [NUM_W-1:0]               den_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [vri_pkg::RatioW-1:0]     ratio_o,
  output logic                           zero_denominator_o
);

  localparam int unsigned RW    = vri_pkg::RatioW;
  localparam int unsigned SC_W  = NUM_W + 7;
  localparam int unsigned DW    = SC_W + FRACTION_BITS;
  localparam int unsigned CNT_W = $clog2(RW);

  vri_pkg::back_state_e state_q, state_d;
  logic [NUM_W-1:0] rem_q, rem_d, den_q, den_d;
  logic [RW-1:0]    low_q, low_d, res_q, res_d;
  logic             zflag_q, zflag_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic [RW-1:0]    ratio_q, ratio_d;
  logic             zero_q, zero_d;

  logic [SC_W-1:0]  num_ext, scaled;
  logic [DW-1:0]    dividend;
  logic [NUM_W:0]   rem_sh, rem_diff;
  logic             q_bit;

  // x100 as 64x + 32x + 4x
  assign num_ext  = SC_W'(num_i);
  assign scaled   = (num_ext << 6) + (num_ext << 5) + (num_ext << 2);
  assign dividend = DW'(scaled) << FRACTION_BITS;

  assign rem_sh   = {rem_q, low_q[RW-1]};
  assign rem_diff = rem_sh - {1'b0, den_q};
  assign q_bit    = (rem_sh >= {1'b0, den_q});

  assign out_valid_o        = out_valid_q;
  assign ratio_o            = ratio_q;
  assign zero_denominator_o = zero_q;

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    den_d   = den_q;
    low_d   = low_q;
    res_d   = res_q;
    zflag_d = zflag_q;
    cnt_d   = cnt_q;
    ratio_d = ratio_q;
    zero_d  = zero_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pop_ready_o = 1'b0;

    case (state_q)
      vri_pkg::B_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          // upper part is below the divisor unless the quotient needs 33+ bits
          rem_d   = NUM_W'(dividend[DW-1:RW]);
          low_d   = dividend[RW-1:0];
          den_d   = den_i;
          state_d = vri_pkg::B_CHK;
        end
      end
      vri_pkg::B_CHK: begin
        if (den_q == '0) begin
          res_d   = '1;
          zflag_d = 1'b1;
          state_d = vri_pkg::B_DONE;
        end else if (rem_q >= den_q) begin
          res_d   = '1;
          zflag_d = 1'b0;
          state_d = vri_pkg::B_DONE;
        end else begin
          res_d   = '0;
          zflag_d = 1'b0;
          cnt_d   = '1;
          state_d = vri_pkg::B_DIV;
        end
      end
      vri_pkg::B_DIV: begin
        rem_d = q_bit ? rem_diff[NUM_W-1:0] : rem_sh[NUM_W-1:0];
        res_d = {res_q[RW-2:0], q_bit};
        low_d = low_q << 1;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = vri_pkg::B_DONE;
        end
      end
      vri_pkg::B_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          ratio_d     = res_q;
          zero_d      = zflag_q;
          out_valid_d = 1'b1;
          state_d     = vri_pkg::B_IDLE;
        end
      end
      default: begin
        state_d = vri_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vri_pkg::B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    den_q   <= den_d;
    low_q   <= low_d;
    res_q   <= res_d;
    zflag_q <= zflag_d;
    cnt_q   <= cnt_d;
    ratio_q <= ratio_d;
    zero_q  <= zero_d;
  end

endmodule

[src/volume_ratio_indicator.sv]
// Volume ratio indicator top level: front end, queue, divider back end.
//
//   channel  direction  handshake                payload
//   cfg      in         cfg_valid_i/cfg_ready_o  window_length_i
//   in       in         in_valid_i/in_ready_o    close_price_i, volume_i
//   out      out        out_valid_o/out_ready_i  ratio_o, zero_denominator_o
//
// Front end: the first bar after a restart only primes the previous close; a bar while the window
// fills does ring read and sum update; a bar that yields a ratio adds a queue push, held while full.
// Back end: each ratio takes load, check, 32 divide steps, hand-off; a saturated ratio or a zero
// denominator skips the divide steps; the divider sets the sustained rate.
// Reset (rst_ni low, asynchronous) sets window 26, clears sums and counts, not the ring;
// a window write restarts the window. The two-beat queue lets each side stall on its own.
module volume_ratio_indicator #(
  parameter int unsigned MAX_WINDOW    = 256,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [vri_pkg::WinW-1:0]     window_length_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [vri_pkg::PriceW-1:0]   close_price_i,
  input  logic [vri_pkg::VolW-1:0]     volume_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [vri_pkg::RatioW-1:0]   ratio_o,
  output logic                         zero_denominator_o
);

  localparam int unsigned SUM_W = vri_pkg::VolW + $clog2(MAX_WINDOW);
  localparam int unsigned NUM_W = SUM_W + 1;

  logic             q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  logic [NUM_W-1:0] f_num, f_den, b_num, b_den;

  vri_front #(
    .MAX_WINDOW (MAX_WINDOW),
    .SUM_W      (SUM_W)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .window_length_i (window_length_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .close_price_i   (close_price_i),
    .volume_i        (volume_i),
    .push_valid_o    (q_push_valid),
    .push_ready_i    (q_push_ready),
    .push_num_o      (f_num),
    .push_den_o      (f_den)
  );

  vri_queue #(
    .W (2 * NUM_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_data_i  ({f_num, f_den}),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_data_o   ({b_num, b_den})
  );

  vri_back #(
    .NUM_W         (NUM_W),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .pop_valid_i        (q_pop_valid),
    .pop_ready_o        (q_pop_ready),
    .num_i              (b_num),
    .den_i              (b_den),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .ratio_o            (ratio_o),
    .zero_denominator_o (zero_denominator_o)
  );

  // a zero denominator always reports the saturated ratio
  a_zero_den_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_denominator_o |-> (&ratio_o))
    else $error("zero denominator beat without saturated ratio");

  // the front end holds a beat the queue could not take
  a_push_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_valid && !q_push_ready |=> q_push_valid && $stable(f_num) && $stable(f_den))
    else $error("front end dropped a beat while the queue was full");

  // no new bar is taken while the front end holds a beat for the queue
  a_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_valid |-> !in_ready_o)
    else $error("bar accepted while a beat is pending");

endmodule
